// ----- rtl/core/uxf_pkg.sv -----
// shared types and constants for the serial port byte fifos
package uxf_pkg;

	// width of a fill count on the result side
	localparam int unsigned FILL_W = 9;

	// operation codes
	localparam logic [2:0] OP_LINE_RX   = 3'd0;
	localparam logic [2:0] OP_POP_RX    = 3'd1;
	localparam logic [2:0] OP_PEEK_RX   = 3'd2;
	localparam logic [2:0] OP_PUSH_TX   = 3'd3;
	localparam logic [2:0] OP_TX_READY  = 3'd4;
	localparam logic [2:0] OP_TX_STATUS = 3'd5;

	// input transaction payload
	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data_byte;
		logic [7:0] peek_offset;
		logic       tx_busy_request;
	} item_t;

	// result transaction payload
	typedef struct packed {
		logic [7:0]        read_byte;
		logic              accepted;
		logic              send_valid;
		logic [7:0]        send_byte;
		logic              tx_kick;
		logic [FILL_W-1:0] rx_fill;
		logic [FILL_W-1:0] tx_fill;
	} result_t;

	// requests into one ring fifo, already qualified by acceptance
	typedef struct packed {
		logic push;
		logic pop;
		logic peek;
	} ring_req_t;

endpackage

// ----- rtl/core/uxf_ring.sv -----
// byte ring fifo with head, tail, fill count, storage and a peek read port
module uxf_ring #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  uxf_pkg::ring_req_t        req,
	input  logic [7:0]                wdata,
	input  logic [7:0]                offset,
	output logic                      ok,
	output logic [7:0]                rdata_q,
	output logic [uxf_pkg::FILL_W-1:0] count_next
);
	import uxf_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [PW:0]   peek_sum;
	logic [PW:0]   peek_wrap;
	logic [PW-1:0] raddr;
	logic          can_push;
	logic          can_pop;
	logic          can_peek;
	logic          do_push;
	logic          do_pop;
	logic          do_read;

	// occupancy checks
	assign can_push = (count_q < DEPTH_C);
	assign can_pop  = (count_q != '0);
	assign can_peek = ({1'b0, offset} < FILL_W'(count_q));

	assign do_push = req.push & can_push;
	assign do_pop  = req.pop & can_pop;
	assign do_read = do_pop | (req.peek & can_peek);

	assign ok = do_push | do_pop | (req.peek & can_peek);

	// peek address, head plus offset wrapped once at depth
	assign peek_sum  = {1'b0, head_q} + (PW + 1)'(offset);
	assign peek_wrap = (peek_sum >= DEPTH_W) ? (peek_sum - DEPTH_W) : peek_sum;
	assign raddr     = req.pop ? head_q : peek_wrap[PW-1:0];

	// fill count after this transaction
	always_comb begin
		count_d = count_q;
		if (do_push) begin
			count_d = count_q + CW'(1);
		end else if (do_pop) begin
			count_d = count_q - CW'(1);
		end
	end
	assign count_next = FILL_W'(count_d);

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_d;
			if (do_push) begin
				tail_q <= (tail_q == LAST_PTR) ? '0 : tail_q + PW'(1);
			end
			if (do_pop) begin
				head_q <= (head_q == LAST_PTR) ? '0 : head_q + PW'(1);
			end
		end
	end

	// storage write
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail_q] <= wdata;
		end
	end

	// storage read, held until the next read
	always_ff @(posedge clk) begin
		if (do_read) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/uart_rx_tx_byte_fifos.sv -----
// Serial port receive and transmit byte fifos: one transaction in per cycle.
// After its transaction is accepted, a result passes the fifo update and
// storage read, then the output register.
// Throughput: one transaction per cycle, limited only by result stall.
// Reset clears pointers, counts, the transmit-active flag and stage valids;
// fifo storage is not cleared.
module uart_rx_tx_byte_fifos #(
	parameter int unsigned DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  uxf_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output uxf_pkg::result_t result
);
	import uxf_pkg::*;

	ring_req_t         rx_req;
	ring_req_t         tx_req;
	logic              rx_ok;
	logic              tx_ok;
	logic [7:0]        rx_rdata_q;
	logic [7:0]        tx_rdata_q;
	logic [FILL_W-1:0] rx_count_next;
	logic [FILL_W-1:0] tx_count_next;
	logic              accept;
	logic              move_s1;
	logic              kick;
	logic              tx_active_q;

	logic              valid_s1;
	logic              rd_sel_s1;
	logic              acc_s1;
	logic              sv_s1;
	logic              kick_s1;
	logic [FILL_W-1:0] rx_fill_s1;
	logic [FILL_W-1:0] tx_fill_s1;
	logic              valid_s2;
	result_t           result_s2;

	// handshake: stage one moves when the output register is free or draining
	assign move_s1    = valid_s1 & (~valid_s2 | ~result_stall);
	assign item_stall = valid_s1 & ~move_s1;
	assign accept     = item_valid & ~item_stall;

	// decode into fifo requests
	always_comb begin
		rx_req = '0;
		tx_req = '0;
		if (accept) begin
			case (item.op)
				OP_LINE_RX:  rx_req.push = 1'b1;
				OP_POP_RX:   rx_req.pop  = 1'b1;
				OP_PEEK_RX:  rx_req.peek = 1'b1;
				OP_PUSH_TX:  tx_req.push = 1'b1;
				OP_TX_READY: tx_req.pop  = 1'b1;
				default:     ;
			endcase
		end
	end

	uxf_ring #(.DEPTH(DEPTH)) u_rx_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (rx_req),
		.wdata      (item.data_byte),
		.offset     (item.peek_offset),
		.ok         (rx_ok),
		.rdata_q    (rx_rdata_q),
		.count_next (rx_count_next)
	);

	uxf_ring #(.DEPTH(DEPTH)) u_tx_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (tx_req),
		.wdata      (item.data_byte),
		.offset     (8'd0),
		.ok         (tx_ok),
		.rdata_q    (tx_rdata_q),
		.count_next (tx_count_next)
	);

	// transmit kick when sending is requested while idle
	assign kick = accept & (item.op == OP_TX_STATUS) & ~tx_active_q & item.tx_busy_request;

	// transmit-active flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_active_q <= 1'b0;
		end else if (accept) begin
			if (item.op == OP_TX_STATUS) begin
				tx_active_q <= item.tx_busy_request;
			end else if (tx_req.pop & ~tx_ok) begin
				tx_active_q <= 1'b0;
			end
		end
	end

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage one payload, fifo read data sits in the ring registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_sel_s1  <= (rx_req.pop | rx_req.peek) & rx_ok;
			acc_s1     <= (rx_req.push | rx_req.pop | rx_req.peek) ? rx_ok
				: (tx_req.push & tx_ok);
			sv_s1      <= tx_req.pop & tx_ok;
			kick_s1    <= kick;
			rx_fill_s1 <= rx_count_next;
			tx_fill_s1 <= tx_count_next;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
		end else if (~result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (move_s1) begin
			result_s2.read_byte  <= rd_sel_s1 ? rx_rdata_q : 8'd0;
			result_s2.accepted   <= acc_s1;
			result_s2.send_valid <= sv_s1;
			result_s2.send_byte  <= sv_s1 ? tx_rdata_q : 8'd0;
			result_s2.tx_kick    <= kick_s1;
			result_s2.rx_fill    <= rx_fill_s1;
			result_s2.tx_fill    <= tx_fill_s1;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule
